[rtl/nsrc_pkg.sv]
// ----------------------------------------------------------------------------
// nsrc_pkg
// Shared types, constants and helpers of the nearest sample rate converter.
// ----------------------------------------------------------------------------
package nsrc_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int STEP_W    = 12;
	localparam int OFF_W     = 13;
	localparam int FRAC_BITS = 8;
	localparam int MAX_OUT   = 16;
	localparam int CNT_W     = $clog2(MAX_OUT);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 12;
	localparam int CODE_W    = 2;

	// one source frame in Q5.8 position units
	localparam logic [OFF_W-1:0]  FRAME_ONE = OFF_W'(1 << FRAC_BITS);
	localparam logic [STEP_W-1:0] MIN_STEP  = STEP_W'(16);
	localparam logic [7:0]        BYTE_BIAS = 8'h80;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Q8       = 2'd2;

	// register codes
	localparam logic [CODE_W-1:0] CH_MONO    = 2'd1;
	localparam logic [CODE_W-1:0] CH_STEREO  = 2'd2;
	localparam logic [CODE_W-1:0] SW_16BIT   = 2'd2;
	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(256);

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	typedef struct packed {
		logic load;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic off_ge_one;
		logic run_done;
	} sts_t;

	// 8-bit samples are unsigned: (byte - 128) << 8 is the flipped sign bit in the high byte
	function automatic logic [SAMPLE_W-1:0] to_s16(input logic [SAMPLE_W-1:0] raw,
			input logic [CODE_W-1:0] width_code);
		logic [SAMPLE_W-1:0] res;
		if (width_code == SW_16BIT) begin
			res = raw;
		end else begin
			res = {raw[7:0] ^ BYTE_BIAS, 8'h00};
		end
		return res;
	endfunction

endpackage

[rtl/nsrc_ctrl.sv]
// ----------------------------------------------------------------------------
// nsrc_ctrl
// Controller: accepts input frames, paces result emission, owns output valid.
// ----------------------------------------------------------------------------
module nsrc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  nsrc_pkg::sts_t  sts,
	output nsrc_pkg::cmd_t  cmd
);
	import nsrc_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && !sts.off_ge_one) begin
					state_nxt = S_RUN;
				end
			end
			S_RUN: begin
				if (slot_free && sts.run_done) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_RUN: begin
				cmd.emit = slot_free;
			end
			default: begin
				in_ready = 1'b0;
				cmd      = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/nsrc_dp.sv]
// ----------------------------------------------------------------------------
// nsrc_dp
// Datapath: config registers, captured frame, position accumulator, result register.
// ----------------------------------------------------------------------------
module nsrc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [nsrc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nsrc_pkg::CFG_DAT_W-1:0]      cfg_data,
	input  logic [nsrc_pkg::SAMPLE_W-1:0]       left_raw,
	input  logic [nsrc_pkg::SAMPLE_W-1:0]       right_raw,
	input  logic                                end_of_sound,
	input  nsrc_pkg::cmd_t                      cmd,
	output nsrc_pkg::sts_t                      sts,
	output logic signed [nsrc_pkg::SAMPLE_W-1:0] left_sample,
	output logic signed [nsrc_pkg::SAMPLE_W-1:0] right_sample,
	output logic                                last_of_run
);
	import nsrc_pkg::*;

	logic [CODE_W-1:0]   chan_q;
	logic [CODE_W-1:0]   width_q;
	logic [STEP_W-1:0]   step_q;
	logic [STEP_W-1:0]   step_eff;
	logic [OFF_W-1:0]    off_q;
	logic [OFF_W-1:0]    off_sum;
	logic [CNT_W-1:0]    cnt_q;
	logic [SAMPLE_W-1:0] left_q;
	logic [SAMPLE_W-1:0] right_q;
	logic                eos_q;
	logic [SAMPLE_W-1:0] out_left_q;
	logic [SAMPLE_W-1:0] out_right_q;
	logic                out_last_q;
	logic                sum_ge_one;

	assign step_eff   = (step_q < MIN_STEP) ? MIN_STEP : step_q;
	assign off_sum    = off_q + OFF_W'(step_eff);
	assign sum_ge_one = off_sum >= FRAME_ONE;

	assign sts.off_ge_one = off_q >= FRAME_ONE;
	assign sts.run_done   = sum_ge_one || (cnt_q == CNT_W'(MAX_OUT - 1));

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q  <= CH_MONO;
			width_q <= SW_16BIT;
			step_q  <= STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHANNEL_COUNT: chan_q  <= cfg_data[CODE_W-1:0];
				REG_SAMPLE_WIDTH:  width_q <= cfg_data[CODE_W-1:0];
				REG_STEP_Q8:       step_q  <= cfg_data[STEP_W-1:0];
				default:           ;
			endcase
		end
	end

	// position accumulator and run counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
			// no output for this frame: just move the position on
			if (sts.off_ge_one) begin
				off_q <= end_of_sound ? '0 : off_q - FRAME_ONE;
			end
		end else if (cmd.emit) begin
			if (sts.run_done) begin
				cnt_q <= '0;
				if (eos_q || !sum_ge_one) begin
					off_q <= '0;
				end else begin
					off_q <= off_sum - FRAME_ONE;
				end
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
				off_q <= off_sum;
			end
		end
	end

	// captured frame
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			left_q  <= to_s16(left_raw, width_q);
			right_q <= (chan_q == CH_STEREO) ? to_s16(right_raw, width_q) : '0;
			eos_q   <= end_of_sound;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_left_q  <= left_q;
			out_right_q <= right_q;
			out_last_q  <= sts.run_done;
		end
	end

	assign left_sample  = out_left_q;
	assign right_sample = out_right_q;
	assign last_of_run  = out_last_q;

endmodule

[rtl/nearest_sample_rate_converter.sv]
// ----------------------------------------------------------------------------
// nearest_sample_rate_converter
// Nearest-neighbor audio resampler with a Q5.8 position accumulator.
// ----------------------------------------------------------------------------
// Each accepted input frame (one or two channels, unsigned 8-bit or signed
// 16-bit) is converted to signed 16-bit and repeated for every output frame
// whose position falls inside it, from zero to sixteen results per input.
// Output frame i of a sound takes source frame floor(i * step / 256), with
// step being step_q8 raised to at least 16; end_of_sound restarts the position
// after its frame. A frame is taken, then its N results leave at one per
// cycle (as long as out_ready keeps up); a frame with no results is absorbed
// in its accept cycle. The pace is set by the single result register, which
// is loaded once per cycle by the emit loop while its slot is free.
// The next frame is taken while the last result of the previous one still
// waits in the result register. Config writes are always taken (cfg_ready
// tied high) and must only happen while the block is idle.
// ----------------------------------------------------------------------------
module nearest_sample_rate_converter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [nsrc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nsrc_pkg::CFG_DAT_W-1:0]       cfg_data,
	// input frame channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [nsrc_pkg::SAMPLE_W-1:0]        left_raw,
	input  logic [nsrc_pkg::SAMPLE_W-1:0]        right_raw,
	input  logic                                 end_of_sound,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [nsrc_pkg::SAMPLE_W-1:0] left_sample,
	output logic signed [nsrc_pkg::SAMPLE_W-1:0] right_sample,
	output logic                                 last_of_run
);
	import nsrc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// config registers never stall
	assign cfg_ready = 1'b1;

	// controller: idle/run sequencing and output valid
	nsrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: sample conversion, position accumulator, result register
	nsrc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.left_raw     (left_raw),
		.right_raw    (right_raw),
		.end_of_sound (end_of_sound),
		.cmd          (cmd),
		.sts          (sts),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.last_of_run  (last_of_run)
	);

`ifndef SYNTHESIS
	// while emitting, the position is always inside the current frame
	a_emit_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.off_ge_one)
		else $error("emit with position past current frame");

	// a frame with no results leaves the block ready for the next one
	a_skip_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && sts.off_ge_one) |=> in_ready)
		else $error("frame with no results did not return to idle");

	// the final result of a run frees the input side
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.run_done) |=> in_ready)
		else $error("run did not end after its final result");

	// a frame is never taken in a cycle that emits a result
	a_load_emit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.emit))
		else $error("load and emit in the same cycle");

	// each emitted result shows up as valid in the next cycle
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (out_valid && (last_of_run == $past(sts.run_done))))
		else $error("emitted result not presented");
`endif

endmodule

[tb/sv/tb_nearest_sample_rate_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_sample_rate_converter
// Self-checking testbench of the nearest-neighbor sample rate converter.
// ----------------------------------------------------------------------------
// Frames go in through a bursty sender, results leave through a receiver
// with its own stall pattern. A predictor tracks the position accumulator
// and the registers, queues the expected output frames per accepted input,
// and a checker compares every result transfer field by field.
// ----------------------------------------------------------------------------
module tb_nearest_sample_rate_converter;
	import nsrc_pkg::*;

	localparam int RANDOM_ITEMS   = 380;
	localparam int RANDOM_RESULTS = 48;
	localparam int SETTLE_CYCLES  = 4;
	localparam int END_CYCLES     = 20;
	localparam int STUCK_LIMIT    = 2000;

	// codes the package leaves unnamed
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
	localparam logic [CODE_W-1:0]    SW_8BIT     = 2'd1;
	localparam logic [CODE_W-1:0]    CODE_LOW    = 2'd0;
	localparam logic [CODE_W-1:0]    CODE_HIGH   = 2'd3;
	localparam logic [STEP_W-1:0]    STEP_ZERO   = STEP_W'(0);
	localparam logic [STEP_W-1:0]    STEP_MAX    = STEP_W'(4095);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_s;
		logic signed [SAMPLE_W-1:0] right_s;
		logic                       last_flag;
	} out_frame_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [SAMPLE_W-1:0]  left_raw;
	logic [SAMPLE_W-1:0]  right_raw;
	logic                 end_of_sound;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic                 last_of_run;

	// predictor copy of the registers and the position accumulator
	logic [CODE_W-1:0] cfg_channels;
	logic [CODE_W-1:0] cfg_width;
	logic [STEP_W-1:0] cfg_step;
	logic [OFF_W-1:0]  frame_pos;

	out_frame_t expected_frames[$];
	int mismatch_count;
	int results_seen;
	int burst_left;
	int rx_run_left;
	int stuck_cycles;
	bit steady;

	nearest_sample_rate_converter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.left_raw     (left_raw),
		.right_raw    (right_raw),
		.end_of_sound (end_of_sound),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.last_of_run  (last_of_run)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// 8-bit samples: flip the sign bit of the low byte and move it up
	function automatic logic [SAMPLE_W-1:0] widen_sample(input logic [SAMPLE_W-1:0] raw);
		if (cfg_width == SW_16BIT) begin
			return raw;
		end
		return {raw[7:0] ^ BYTE_BIAS, 8'h00};
	endfunction

	// queue every output frame whose position falls inside this input frame
	function automatic void resample_frame(input logic [SAMPLE_W-1:0] l_raw,
			input logic [SAMPLE_W-1:0] r_raw, input logic eos);
		out_frame_t f;
		logic [OFF_W-1:0] stride;
		int n;
		f.left_s    = widen_sample(l_raw);
		f.right_s   = (cfg_channels == CH_STEREO) ? widen_sample(r_raw) : '0;
		f.last_flag = 1'b0;
		// steps under the floor count as the floor, which caps a run at sixteen
		stride = (cfg_step < MIN_STEP) ? OFF_W'(MIN_STEP) : OFF_W'(cfg_step);
		n = 0;
		while (frame_pos < FRAME_ONE && n < MAX_OUT) begin
			expected_frames.push_back(f);
			frame_pos = frame_pos + stride;
			n++;
		end
		if (n > 0) begin
			expected_frames[expected_frames.size() - 1].last_flag = 1'b1;
		end
		frame_pos = (frame_pos >= FRAME_ONE) ? frame_pos - FRAME_ONE : '0;
		// a sound ends: next sound starts at position zero
		if (eos) begin
			frame_pos = '0;
		end
	endfunction

	// ------------------------------------------------------------------
	// result checker, sampled at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		out_frame_t exp_f;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_frames.size() == 0) begin
				$display("%0t: result with none expected: left %0d right %0d last %0b",
					$time, left_sample, right_sample, last_of_run);
				mismatch_count++;
			end else begin
				exp_f = expected_frames.pop_front();
				if (left_sample !== exp_f.left_s) begin
					$display("%0t: left_sample expected %0d actual %0d",
						$time, exp_f.left_s, left_sample);
					mismatch_count++;
				end
				if (right_sample !== exp_f.right_s) begin
					$display("%0t: right_sample expected %0d actual %0d",
						$time, exp_f.right_s, right_sample);
					mismatch_count++;
				end
				if (last_of_run !== exp_f.last_flag) begin
					$display("%0t: last_of_run expected %0b actual %0b",
						$time, exp_f.last_flag, last_of_run);
					mismatch_count++;
				end
			end
		end
	end

	// receiver: runs of ready and stalls of random length, an occasional long stall; always ready when steady
	always @(negedge clk) begin
		if (steady) begin
			out_ready <= 1'b1;
		end else if (rx_run_left == 0) begin
			out_ready <= !out_ready;
			if (out_ready) begin
				rx_run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24)
					: $urandom_range(1, 6);
			end else begin
				rx_run_left = $urandom_range(1, 12);
			end
		end else begin
			rx_run_left--;
		end
	end

	// watchdog: too many cycles without any transfer ends the run
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
		end
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// shared driving tasks
	// ------------------------------------------------------------------

	// one input frame; bursts of random length with random gaps in between
	task automatic send_frame(input logic [SAMPLE_W-1:0] l_raw,
			input logic [SAMPLE_W-1:0] r_raw, input logic eos);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid     <= 1'b1;
		left_raw     <= l_raw;
		right_raw    <= r_raw;
		end_of_sound <= eos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		resample_frame(l_raw, r_raw, eos);
	endtask

	// all expected results in, then a settle wait for frames that emit nothing
	task automatic wait_until_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_CHANNEL_COUNT: cfg_channels = data[CODE_W-1:0];
			REG_SAMPLE_WIDTH:  cfg_width    = data[CODE_W-1:0];
			REG_STEP_Q8:       cfg_step     = data[STEP_W-1:0];
			default: ;	// unused index, write dropped
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// code in the low bits, junk above it
	function automatic logic [CFG_DAT_W-1:0] code_word(input logic [CODE_W-1:0] code);
		return {(CFG_DAT_W - CODE_W)'($urandom), code};
	endfunction

	// raw sample with extra weight on the extremes of both formats
	function automatic logic [SAMPLE_W-1:0] pick_raw();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			4: return {8'($urandom), 8'h80};
			5: return {8'($urandom), 8'h7F};
			default: return 16'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset registers: mono, 16-bit, unit step, one result per frame; then stereo
	task automatic test_default_registers();
		send_frame(16'h0000, 16'hFFFF, 1'b0);
		send_frame(16'hFFFF, 16'h1234, 1'b0);
		send_frame(16'h8000, 16'h8000, 1'b0);
		send_frame(16'h7FFF, 16'h7FFF, 1'b1);
		wait_until_idle();
		write_register(REG_CHANNEL_COUNT, code_word(CH_STEREO));
		send_frame(16'h8000, 16'h7FFF, 1'b0);
		send_frame(16'h7FFF, 16'h8000, 1'b1);
		send_frame(16'hFFFF, 16'h0000, 1'b1);
	endtask

	// unsigned 8-bit samples, and odd codes acting as mono and 8-bit
	task automatic test_eight_bit_and_odd_codes();
		wait_until_idle();
		write_register(REG_SAMPLE_WIDTH, code_word(SW_8BIT));
		send_frame(16'hA500, 16'h0080, 1'b0);
		send_frame(16'h3CFF, 16'hFF7F, 1'b1);
		wait_until_idle();
		write_register(REG_SAMPLE_WIDTH, code_word(CODE_LOW));
		write_register(REG_CHANNEL_COUNT, code_word(CODE_HIGH));
		send_frame(16'h1280, 16'h55AA, 1'b1);
		wait_until_idle();
		write_register(REG_SAMPLE_WIDTH, code_word(CODE_HIGH));
		write_register(REG_CHANNEL_COUNT, code_word(CODE_LOW));
		send_frame(16'h00FF, 16'hFFFF, 1'b1);
		wait_until_idle();
		write_register(REG_SAMPLE_WIDTH, code_word(SW_16BIT));
		write_register(REG_CHANNEL_COUNT, code_word(CH_STEREO));
	endtask

	// step floor, full sixteen-result runs, huge step, change mid-sound, unused index
	task automatic test_step_extremes();
		wait_until_idle();
		// zero step behaves as the floor: sixteen results
		write_register(REG_STEP_Q8, STEP_ZERO);
		send_frame(16'h1111, 16'h2222, 1'b1);
		wait_until_idle();
		write_register(REG_STEP_Q8, MIN_STEP);
		send_frame(16'h8001, 16'h7FFE, 1'b0);
		send_frame(16'hFFFE, 16'h0001, 1'b1);
		wait_until_idle();
		// largest step: most frames emit nothing
		write_register(REG_STEP_Q8, STEP_MAX);
		send_frame(16'h4321, 16'hBCDE, 1'b0);
		send_frame(16'h5555, 16'hAAAA, 1'b0);
		send_frame(16'hAAAA, 16'h5555, 1'b1);
		wait_until_idle();
		write_register(REG_STEP_Q8, STEP_W'(384));
		send_frame(16'h0102, 16'h0304, 1'b0);
		send_frame(16'h0506, 16'h0708, 1'b0);
		// step changes inside a sound, position carries over
		wait_until_idle();
		write_register(REG_STEP_Q8, STEP_W'(128));
		send_frame(16'h090A, 16'h0B0C, 1'b0);
		send_frame(16'h0D0E, 16'h0F10, 1'b1);
		// write to the unused index must change nothing
		wait_until_idle();
		write_register(REG_UNUSED, 12'hFFF);
		send_frame(16'hC0DE, 16'h0BAD, 1'b1);
	endtask

	task automatic configure_random();
		logic [STEP_W-1:0] stride;
		write_register(REG_CHANNEL_COUNT, ($urandom_range(0, 1) == 0) ? CFG_DAT_W'($urandom)
			: code_word(($urandom_range(0, 1) == 0) ? CH_MONO : CH_STEREO));
		write_register(REG_SAMPLE_WIDTH, ($urandom_range(0, 1) == 0) ? CFG_DAT_W'($urandom)
			: code_word(($urandom_range(0, 1) == 0) ? SW_8BIT : SW_16BIT));
		case ($urandom_range(0, 7))
			0: stride = STEP_W'($urandom_range(0, 15));
			1: stride = MIN_STEP;
			2: stride = STEP_MAX;
			3: stride = STEP_RESET;
			4, 5: stride = STEP_W'($urandom_range(16, 600));
			default: stride = STEP_W'($urandom_range(16, 4095));
		endcase
		write_register(REG_STEP_Q8, stride);
		if ($urandom_range(0, 5) == 0) begin
			write_register(REG_UNUSED, CFG_DAT_W'($urandom));
		end
	endtask

	// random settings, mostly whole sounds, some frames with stray end marks
	task automatic test_random_sounds();
		int random_items;
		int results_base;
		int len;
		int k;
		bit noisy;
		logic eos;
		random_items = 0;
		results_base = results_seen;
		while (random_items < RANDOM_ITEMS || results_seen - results_base < RANDOM_RESULTS) begin
			wait_until_idle();
			configure_random();
			steady = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(2, 6)) begin
				noisy = ($urandom_range(0, 6) == 0);
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
				for (k = 0; k < len; k++) begin
					eos = noisy ? 1'($urandom_range(0, 1)) : (k == len - 1);
					send_frame(pick_raw(), pick_raw(), eos);
					random_items++;
				end
			end
		end
		steady = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		left_raw     = '0;
		right_raw    = '0;
		end_of_sound = 1'b0;
		out_ready    = 1'b0;
		steady       = 1'b0;
		burst_left   = 0;
		rx_run_left  = 0;
		stuck_cycles = 0;
		mismatch_count = 0;
		results_seen   = 0;
		cfg_channels = CH_MONO;
		cfg_width    = SW_16BIT;
		cfg_step     = STEP_RESET;
		frame_pos    = '0;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_default_registers();
		test_eight_bit_and_odd_codes();
		test_step_extremes();
		test_random_sounds();

		// drain, then watch a while for stray results
		wait_until_idle();
		repeat (END_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_frames.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
